// File: rtl/pdf_pkg.sv
// Shared constants, types and helpers for the packet descriptor FIFO.
package pdf_pkg;

  localparam int QUEUE_DEPTH  = 64;
  localparam int BUFFER_BYTES = 4096;
  localparam int MAX_PAYLOAD  = 504;

  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PW  = $clog2(BUFFER_BYTES + 1);
  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int RW  = AW - 3;
  localparam int ROWS = BUFFER_BYTES / 8;
  localparam int LW  = 9;
  localparam int DW  = 64 + LW + PW;

  typedef enum logic [1:0] {
    REQ_PUSH  = 2'd0,
    REQ_POP   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_BIG     = 3'd2,
    ST_FULL    = 3'd3,
    ST_NOSPACE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DESC,
    S_HDR,
    S_RDW,
    S_WORD
  } state_t;

  typedef struct packed {
    logic          en;
    logic [PW-1:0] base;
    logic [3:0]    take;
    logic [63:0]   word;
  } st_wr_t;

  typedef struct packed {
    logic          en;
    logic [PW-1:0] base;
  } st_rd_t;

  // Bytes between read and write positions, wrap-aware.
  function automatic logic [12:0] used_f(logic [PW-1:0] rp, logic [PW-1:0] wp);
    logic [31:0] u;
    if (wp >= rp) u = 32'(wp) - 32'(rp);
    else          u = 32'(BUFFER_BYTES) - 32'(rp) + 32'(wp);
    return u[12:0];
  endfunction

endpackage

// File: rtl/pdf_if.sv
// Request and result channel interfaces.
interface pdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        first;
  logic [63:0] header;
  logic [8:0]  push_size;
  logic [63:0] data_word;
  logic [8:0]  max_len;

  modport source (output valid, req_type, first, header, push_size, data_word, max_len,
                  input ready);
  modport sink   (input valid, req_type, first, header, push_size, data_word, max_len,
                  output ready);
endinterface

interface pdf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [63:0] out_header;
  logic [8:0]  length;
  logic [63:0] out_word;
  logic [3:0]  valid_bytes;
  logic        last;
  logic [6:0]  pending_count;
  logic [12:0] used_bytes;

  modport source (output valid, status, out_header, length, out_word, valid_bytes, last,
                  pending_count, used_bytes, input ready);
  modport sink   (input valid, status, out_header, length, out_word, valid_bytes, last,
                  pending_count, used_bytes, output ready);
endinterface

// File: rtl/packet_descriptor_fifo_unit.sv
// Packet descriptor FIFO top level: sequencer, descriptor ring and payload byte store.
// Push: one request per cycle while the result slot is free; result registered on acceptance.
// Pop or peek: descriptor read, header result; a pop then does a store read and an emit per word.
// Empty pop or peek, and clear: one result, one request per cycle while the result slot is free.
// Reset (synchronous, active low) empties the queue; stores are not cleared.
module packet_descriptor_fifo_unit (
  input  logic        clk,
  input  logic        rst_n,
  pdf_in_if.sink      in_chan,
  pdf_out_if.source   out_chan
);
  import pdf_pkg::*;

  state_t           state_r, state_nxt;
  logic [QIW-1:0]   head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [PW-1:0]    rp_r, rp_nxt, wp_r, wp_nxt, open_off_r, open_off_nxt;
  logic [LW-1:0]    br_r, br_nxt;
  logic             drop_r, drop_nxt;
  logic             is_pop_r;
  logic [LW-1:0]    maxl_r, len_r, n_r, pos_r;
  logic [63:0]      hdr_r;
  logic [PW-1:0]    off_r;

  logic             ov_r;
  logic [2:0]       o_st_r;
  logic [63:0]      o_hdr_r, o_word_r;
  logic [LW-1:0]    o_len_r;
  logic [3:0]       o_vb_r;
  logic             o_last_r;
  logic [6:0]       o_cnt_r;
  logic [12:0]      o_used_r;

  logic             slot_free, in_acc, ld;
  logic [2:0]       ld_st;
  logic [63:0]      ld_hdr, ld_word;
  logic [LW-1:0]    ld_len;
  logic [3:0]       ld_vb;
  logic             ld_last;

  logic             d_we, d_re;
  logic [DW-1:0]    d_wdata, d_q;
  st_wr_t           swr;
  st_rd_t           srd;
  logic [63:0]      s_word;

  logic [LW-1:0]    rem;
  logic             word_last;

  assign slot_free = !ov_r || out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) && slot_free;
  assign in_acc = in_chan.valid && in_chan.ready;
  assign rem = n_r - pos_r;
  assign word_last = (32'(pos_r) + 32'd8) >= 32'(n_r);

  pdf_ram #(.W(DW), .D(QUEUE_DEPTH)) u_desc (
    .clk   (clk),
    .we    (d_we),
    .waddr (tail_r),
    .wdata (d_wdata),
    .re    (d_re),
    .raddr (head_r),
    .rdata (d_q)
  );

  pdf_store u_store (
    .clk     (clk),
    .wr      (swr),
    .rd      (srd),
    .rd_word (s_word)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && (in_chan.req_type == REQ_POP || in_chan.req_type == REQ_PEEK)
            && cnt_r != '0)
          state_nxt = S_DESC;
      end
      S_DESC: state_nxt = S_HDR;
      S_HDR: begin
        if (slot_free) state_nxt = (is_pop_r && n_r != '0) ? S_RDW : S_IDLE;
      end
      S_RDW: state_nxt = S_WORD;
      S_WORD: begin
        if (slot_free) state_nxt = word_last ? S_IDLE : S_RDW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and queue bookkeeping.
  always_comb begin
    logic [PW-1:0] wp1, rp1, wp2, wp3, wp_e;
    logic [LW-1:0] br_e, br_a;
    logic          drop_e, wrap, commit;
    logic [3:0]    take;
    status_t       st;
    head_nxt = head_r; tail_nxt = tail_r; cnt_nxt = cnt_r;
    rp_nxt = rp_r; wp_nxt = wp_r; br_nxt = br_r; drop_nxt = drop_r;
    open_off_nxt = open_off_r;
    ld = 1'b0; ld_st = ST_OK; ld_hdr = '0; ld_len = '0; ld_word = '0; ld_vb = '0;
    ld_last = 1'b1;
    d_we = 1'b0; d_re = 1'b0; d_wdata = '0;
    swr = '0; srd = '0;
    wp1 = wp_r; rp1 = rp_r; wp2 = wp_r; wp3 = wp_r; wp_e = wp_r;
    br_e = br_r; br_a = '0; drop_e = drop_r; wrap = 1'b0; commit = 1'b0; take = '0;
    st = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ld = 1'b1;
          unique case (req_t'(in_chan.req_type))
            REQ_PUSH: begin
              if (in_chan.first) begin
                // Abandon any open packet and release its space.
                if (br_r != '0 && !drop_r) begin
                  wp1 = open_off_r;
                  if (cnt_r == '0) begin
                    wp1 = '0;
                    rp1 = '0;
                  end
                end
                if (32'(in_chan.push_size) > 32'(MAX_PAYLOAD)) st = ST_BIG;
                else if (32'(cnt_r) >= 32'(QUEUE_DEPTH)) st = ST_FULL;
                else if (wp1 < rp1) begin
                  if (32'(in_chan.push_size) >= 32'(rp1) - 32'(wp1)) st = ST_NOSPACE;
                end else if (32'(BUFFER_BYTES) - 32'(wp1) < 32'(in_chan.push_size)) begin
                  if (32'(rp1) > 32'(in_chan.push_size)) wrap = 1'b1;
                  else st = ST_NOSPACE;
                end
                wp2 = wrap ? '0 : wp1;
                wp3 = wp1;
                if (st == ST_OK) begin
                  d_we = 1'b1;
                  d_wdata = {in_chan.header, in_chan.push_size, wp2};
                  wp3 = PW'(32'(wp2) + 32'(in_chan.push_size));
                  open_off_nxt = wp2;
                end
                rp_nxt = rp1;
                br_e = in_chan.push_size;
                drop_e = (st != ST_OK);
                wp_e = wp3;
              end
              take = (br_e < LW'(8)) ? br_e[3:0] : 4'd8;
              br_a = br_e - LW'(take);
              swr.en = !drop_e;
              swr.base = wp_e - PW'(br_e);
              swr.take = take;
              swr.word = in_chan.data_word;
              commit = !drop_e && br_a == '0 && (in_chan.first || br_r != '0);
              if (commit) begin
                tail_nxt = (tail_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
                cnt_nxt = cnt_r + 1'b1;
              end
              wp_nxt = wp_e;
              br_nxt = br_a;
              drop_nxt = (br_a == '0) ? 1'b0 : drop_e;
              ld_st = st;
              ld_last = (br_a == '0);
            end
            REQ_POP, REQ_PEEK: begin
              if (cnt_r == '0) ld_st = ST_EMPTY;
              else begin
                ld = 1'b0;
                d_re = 1'b1;
              end
            end
            REQ_CLEAR: begin
              head_nxt = '0; tail_nxt = '0; cnt_nxt = '0;
              rp_nxt = '0; wp_nxt = '0; br_nxt = '0; drop_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      S_DESC: begin
        if (is_pop_r) begin
          rp_nxt = PW'(32'(d_q[PW-1:0]) + 32'(d_q[PW +: LW]));
          head_nxt = (head_r == QIW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            if (br_r != '0 && !drop_r) rp_nxt = open_off_r;
            else begin
              rp_nxt = '0;
              wp_nxt = '0;
            end
          end
        end
      end
      S_HDR: begin
        ld = slot_free;
        ld_hdr = hdr_r;
        ld_len = is_pop_r ? n_r : len_r;
        ld_last = !is_pop_r || n_r == '0;
      end
      S_RDW: begin
        srd.en = 1'b1;
        srd.base = PW'(32'(off_r) + 32'(pos_r));
      end
      S_WORD: begin
        ld = slot_free;
        ld_hdr = hdr_r;
        ld_len = n_r;
        ld_vb = (rem < LW'(8)) ? rem[3:0] : 4'd8;
        for (int i = 0; i < 8; i++)
          ld_word[8*i +: 8] = (4'(i) < ld_vb) ? s_word[8*i +: 8] : 8'h00;
        ld_last = word_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r <= '0; tail_r <= '0; cnt_r <= '0;
      rp_r <= '0; wp_r <= '0; br_r <= '0; drop_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r <= head_nxt; tail_r <= tail_nxt; cnt_r <= cnt_nxt;
      rp_r <= rp_nxt; wp_r <= wp_nxt; br_r <= br_nxt; drop_r <= drop_nxt;
      if (ld) ov_r <= 1'b1;
      else if (out_chan.ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    open_off_r <= open_off_nxt;
    if (in_acc) begin
      is_pop_r <= (in_chan.req_type == REQ_POP);
      maxl_r <= in_chan.max_len;
    end
    if (state_r == S_DESC) begin
      hdr_r <= d_q[DW-1 -: 64];
      len_r <= d_q[PW +: LW];
      off_r <= d_q[PW-1:0];
      n_r <= (d_q[PW +: LW] <= maxl_r) ? d_q[PW +: LW] : maxl_r;
      pos_r <= '0;
    end else if (state_r == S_WORD && slot_free) begin
      pos_r <= pos_r + LW'(8);
    end
    if (ld) begin
      o_st_r <= ld_st;
      o_hdr_r <= ld_hdr;
      o_len_r <= ld_len;
      o_word_r <= ld_word;
      o_vb_r <= ld_vb;
      o_last_r <= ld_last;
      o_cnt_r <= 7'(cnt_nxt);
      o_used_r <= used_f(rp_nxt, wp_nxt);
    end
  end

  assign out_chan.valid         = ov_r;
  assign out_chan.status        = o_st_r;
  assign out_chan.out_header    = o_hdr_r;
  assign out_chan.length        = o_len_r;
  assign out_chan.out_word      = o_word_r;
  assign out_chan.valid_bytes   = o_vb_r;
  assign out_chan.last          = o_last_r;
  assign out_chan.pending_count = o_cnt_r;
  assign out_chan.used_bytes    = o_used_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= 32'(QUEUE_DEPTH)) else $error("packet count over depth");

  a_drop_open: assert property (@(posedge clk) disable iff (!rst_n)
    drop_r |-> br_r != '0) else $error("dropping with no open packet");

  a_desc_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DESC) |-> $past(state_r == S_IDLE && d_re))
    else $error("descriptor read state without a read");

  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_chan.ready) |-> !ld) else $error("result overwritten while held");
endmodule

// File: rtl/pdf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pdf_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

// File: rtl/pdf_store.sv
// Payload byte store: eight byte banks, one word written or read per cycle at any offset.
module pdf_store (
  input  logic                 clk,
  input  pdf_pkg::st_wr_t      wr,
  input  pdf_pkg::st_rd_t      rd,
  output logic [63:0]          rd_word
);
  import pdf_pkg::*;

  logic [7:0]    we;
  logic [RW-1:0] wrow [8];
  logic [7:0]    wbyte [8];
  logic [RW-1:0] rrow [8];
  logic [7:0]    q [8];
  logic [PW-1:0] rbase_r;

  always_comb begin
    logic [31:0] a;
    for (int b = 0; b < 8; b++) begin
      we[b]    = 1'b0;
      wrow[b]  = '0;
      wbyte[b] = '0;
      rrow[b]  = '0;
      for (int i = 0; i < 8; i++) begin
        a = 32'(wr.base) + 32'(i);
        if (a[2:0] == 3'(b)) begin
          wrow[b]  = a[AW-1:3];
          wbyte[b] = wr.word[8*i +: 8];
          we[b]    = wr.en && (32'(i) < 32'(wr.take)) && (a < 32'(BUFFER_BYTES));
        end
        a = 32'(rd.base) + 32'(i);
        if (a[2:0] == 3'(b)) rrow[b] = a[AW-1:3];
      end
    end
  end

  for (genvar g = 0; g < 8; g++) begin : g_bank
    pdf_ram #(.W(8), .D(ROWS)) u_bank (
      .clk   (clk),
      .we    (we[g]),
      .waddr (wrow[g]),
      .wdata (wbyte[g]),
      .re    (rd.en),
      .raddr (rrow[g]),
      .rdata (q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rd.en) rbase_r <= rd.base;
  end

  // Rotate bank outputs back into byte order; drop bytes past the end.
  always_comb begin
    logic [31:0] a;
    rd_word = '0;
    for (int i = 0; i < 8; i++) begin
      a = 32'(rbase_r) + 32'(i);
      if (a < 32'(BUFFER_BYTES)) rd_word[8*i +: 8] = q[a[2:0]];
    end
  end
endmodule

// File: tb/tb_packet_descriptor_fifo_unit.sv
// Testbench for the packet FIFO: directed and random requests checked against a built-in predictor.
`timescale 1ns / 100ps

module tb_packet_descriptor_fifo_unit;
  import pdf_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    req_t        kind;
    bit          first;
    logic [63:0] header;
    logic [8:0]  push_size;
    logic [63:0] data_word;
    logic [8:0]  max_len;
  } fifo_req_t;

  typedef struct {
    status_t     status;
    logic [63:0] header;
    logic [8:0]  length;
    logic [63:0] word;
    logic [3:0]  valid_bytes;
    logic        last;
    logic [6:0]  pending;
    logic [12:0] used;
  } fifo_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pdf_in_if  in_ch ();
  pdf_out_if out_ch ();

  packet_descriptor_fifo_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_ch),
    .out_chan(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  fifo_req_t pending_reqs[$];
  fifo_res_t expected_results[$];
  fifo_req_t cur_req;
  int src_idle_pct = 19;
  int snk_idle_pct = 70;
  bit hold_req = 1'b0;
  int errors = 0;
  int checked = 0;
  int status_seen[5];
  int packets_popped = 0;

  // Shadow state of the FIFO.
  logic [63:0] sh_hdr [QUEUE_DEPTH];
  int unsigned sh_len [QUEUE_DEPTH];
  int unsigned sh_off [QUEUE_DEPTH];
  logic [7:0]  payload_mem [BUFFER_BYTES];
  int unsigned sh_head, sh_tail, sh_count, sh_rd, sh_wr, sh_rem;
  bit          sh_drop;

  function automatic void shadow_clear();
    sh_head = 0; sh_tail = 0; sh_count = 0;
    sh_rd = 0; sh_wr = 0; sh_rem = 0; sh_drop = 1'b0;
  endfunction

  function automatic void commit_packet();
    sh_tail = (sh_tail + 1) % QUEUE_DEPTH;
    sh_count++;
  endfunction

  function automatic bit store_word(logic [63:0] w);
    int unsigned take, base;
    take = (sh_rem < 8) ? sh_rem : 8;
    if (!sh_drop) begin
      base = sh_wr - sh_rem;
      for (int unsigned i = 0; i < take; i++)
        if (base + i < BUFFER_BYTES) payload_mem[base + i] = w[8*i +: 8];
    end
    sh_rem -= take;
    if (sh_rem != 0) return 1'b0;
    if (!sh_drop) commit_packet();
    sh_drop = 1'b0;
    return 1'b1;
  endfunction

  function automatic status_t admit(int unsigned size);
    if (size > MAX_PAYLOAD) return ST_BIG;
    if (sh_count >= QUEUE_DEPTH) return ST_FULL;
    if (sh_wr < sh_rd) begin
      if (size >= sh_rd - sh_wr) return ST_NOSPACE;
    end else if (BUFFER_BYTES - sh_wr < size) begin
      if (sh_rd > size) sh_wr = 0;
      else return ST_NOSPACE;
    end
    return ST_OK;
  endfunction

  function automatic fifo_res_t mk(status_t s, logic [63:0] h, int unsigned l,
                                   logic [63:0] w, int unsigned vb, bit lst);
    fifo_res_t r;
    r.status = s; r.header = h; r.length = l[8:0]; r.word = w;
    r.valid_bytes = vb[3:0]; r.last = lst; r.pending = '0; r.used = '0;
    return r;
  endfunction

  function automatic void predict_fifo_step(fifo_req_t rq);
    fifo_res_t batch[$];
    status_t st;
    int unsigned size, h, n, vb, used;
    bit done;
    logic [63:0] w;
    case (rq.kind)
      REQ_PUSH: begin
        if (rq.first) begin
          // Abandon an open packet and release its space.
          if (sh_rem != 0) begin
            if (!sh_drop) begin
              sh_wr = sh_off[sh_tail];
              if (sh_count == 0) begin
                sh_rd = 0; sh_wr = 0;
              end
            end
            sh_rem = 0; sh_drop = 1'b0;
          end
          size = rq.push_size;
          st = admit(size);
          if (st == ST_OK) begin
            sh_hdr[sh_tail] = rq.header;
            sh_len[sh_tail] = size;
            sh_off[sh_tail] = sh_wr;
            sh_wr += size;
          end
          sh_rem = size;
          sh_drop = (st != ST_OK);
          if (size == 0) begin
            if (st == ST_OK) commit_packet();
            sh_drop = 1'b0;
            done = 1'b1;
          end else begin
            done = store_word(rq.data_word);
          end
          batch.push_back(mk(st, '0, 0, '0, 0, done));
        end else if (sh_rem == 0) begin
          batch.push_back(mk(ST_OK, '0, 0, '0, 0, 1'b1));
        end else begin
          done = store_word(rq.data_word);
          batch.push_back(mk(ST_OK, '0, 0, '0, 0, done));
        end
      end
      REQ_POP: begin
        if (sh_count == 0) begin
          batch.push_back(mk(ST_EMPTY, '0, 0, '0, 0, 1'b1));
        end else begin
          h = sh_head;
          n = (sh_len[h] <= rq.max_len) ? sh_len[h] : rq.max_len;
          batch.push_back(mk(ST_OK, sh_hdr[h], n, '0, 0, n == 0));
          for (int unsigned pos = 0; pos < n; pos += 8) begin
            vb = (n - pos < 8) ? n - pos : 8;
            w = '0;
            for (int unsigned i = 0; i < vb; i++)
              w |= 64'(payload_mem[sh_off[h] + pos + i]) << (8 * i);
            batch.push_back(mk(ST_OK, sh_hdr[h], n, w, vb, pos + 8 >= n));
          end
          sh_rd = sh_off[h] + sh_len[h];
          sh_head = (sh_head + 1) % QUEUE_DEPTH;
          sh_count--;
          packets_popped++;
          if (sh_count == 0) begin
            // Keep the read position at a packet still being stored.
            if (sh_rem != 0 && !sh_drop) sh_rd = sh_off[sh_tail];
            else begin
              sh_rd = 0; sh_wr = 0;
            end
          end
        end
      end
      REQ_PEEK: begin
        if (sh_count == 0) batch.push_back(mk(ST_EMPTY, '0, 0, '0, 0, 1'b1));
        else batch.push_back(mk(ST_OK, sh_hdr[sh_head], sh_len[sh_head], '0, 0, 1'b1));
      end
      default: begin
        shadow_clear();
        batch.push_back(mk(ST_OK, '0, 0, '0, 0, 1'b1));
      end
    endcase
    used = (sh_wr >= sh_rd) ? sh_wr - sh_rd : BUFFER_BYTES - sh_rd + sh_wr;
    foreach (batch[k]) begin
      batch[k].pending = sh_count[6:0];
      batch[k].used = used[12:0];
      expected_results.push_back(batch[k]);
    end
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    if (errors < 30)
      $display("%0t: mismatch on %s: got %0h, expected %0h", $time, field, got, want);
    errors++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_fifo_step(cur_req);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.req_type  <= cur_req.kind;
          in_ch.first     <= cur_req.first;
          in_ch.header    <= cur_req.header;
          in_ch.push_size <= cur_req.push_size;
          in_ch.data_word <= cur_req.data_word;
          in_ch.max_len   <= cur_req.max_len;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and receiver backpressure.
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    fifo_res_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", out_ch.status, 0);
        end else begin
          e = expected_results.pop_front();
          if (out_ch.status <= 3'd4) status_seen[out_ch.status]++;
          if (out_ch.status !== e.status) report_mismatch("status", out_ch.status, e.status);
          if (out_ch.out_header !== e.header)
            report_mismatch("out_header", out_ch.out_header, e.header);
          if (out_ch.length !== e.length) report_mismatch("length", out_ch.length, e.length);
          if (out_ch.out_word !== e.word) report_mismatch("out_word", out_ch.out_word, e.word);
          if (out_ch.valid_bytes !== e.valid_bytes)
            report_mismatch("valid_bytes", out_ch.valid_bytes, e.valid_bytes);
          if (out_ch.last !== e.last) report_mismatch("last", out_ch.last, e.last);
          if (out_ch.pending_count !== e.pending)
            report_mismatch("pending_count", out_ch.pending_count, e.pending);
          if (out_ch.used_bytes !== e.used)
            report_mismatch("used_bytes", out_ch.used_bytes, e.used);
        end
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Watchdog on cycles with no request or result moving.
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic fifo_req_t req(req_t k, bit f = 1'b0, logic [8:0] sz = '0,
                                    logic [8:0] ml = '0);
    fifo_req_t r;
    r.kind = k; r.first = f; r.header = rand64(); r.push_size = sz;
    r.data_word = rand64(); r.max_len = ml;
    return r;
  endfunction

  // Queue one packet's pushes: a first item, then further words up to the given word count.
  task automatic add_packet(int unsigned size, int unsigned words);
    pending_reqs.push_back(req(REQ_PUSH, 1'b1, size[8:0]));
    for (int unsigned i = 1; i < words; i++) pending_reqs.push_back(req(REQ_PUSH));
  endtask

  function automatic int unsigned words_of(int unsigned size);
    return (size == 0) ? 1 : (size + 7) / 8;
  endfunction

  task automatic add_random(int count);
    int unsigned sel, size;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 55) begin
        size = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(48);
        add_packet(size, words_of(size));
      end else if (sel < 80) begin
        pending_reqs.push_back(req(REQ_POP, 1'b0, '0,
                               $urandom_range(1) ? 9'd511 : 9'($urandom_range(511))));
      end else if (sel < 87) begin
        pending_reqs.push_back(req(REQ_PEEK));
      end else if (sel < 90) begin
        pending_reqs.push_back(req(REQ_CLEAR));
      end else if (sel < 95) begin
        pending_reqs.push_back(req(REQ_PUSH));
      end else begin
        // Broken packet: cut short, the next first abandons it.
        size = $urandom_range(17, 64);
        add_packet(size, $urandom_range(1, words_of(size) - 1));
      end
    end
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    fifo_req_t r;
    in_ch.valid = 1'b0; in_ch.req_type = REQ_PUSH; in_ch.first = 1'b0;
    in_ch.header = '0; in_ch.push_size = '0; in_ch.data_word = '0; in_ch.max_len = '0;
    out_ch.ready = 1'b0;
    shadow_clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed corner cases.
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd511));
    pending_reqs.push_back(req(REQ_PEEK));
    r = req(REQ_PUSH, 1'b1, 9'd0);
    r.header = '1; r.data_word = '1;
    pending_reqs.push_back(r);
    pending_reqs.push_back(req(REQ_PUSH, 1'b1, 9'd511));   // too big, then dropped
    r = req(REQ_PUSH, 1'b1, 9'd13);
    r.data_word = '1;
    pending_reqs.push_back(r);
    pending_reqs.push_back(req(REQ_PUSH));                 // partial last word
    pending_reqs.push_back(req(REQ_PUSH));                 // stray word
    pending_reqs.push_back(req(REQ_PEEK));
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd0));
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd511));
    pending_reqs.push_back(req(REQ_PUSH, 1'b1, 9'd20));
    add_packet(9, 2);                                      // abandons the open packet
    add_packet(16, 2);
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd5));
    pending_reqs.push_back(req(REQ_PUSH, 1'b1, 9'd24));
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd504)); // empties while storing
    pending_reqs.push_back(req(REQ_PUSH));
    pending_reqs.push_back(req(REQ_PUSH));
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd511));
    pending_reqs.push_back(req(REQ_PUSH, 1'b1, 9'd16));
    pending_reqs.push_back(req(REQ_CLEAR));
    pending_reqs.push_back(req(REQ_POP, 1'b0, '0, 9'd511));
    add_random(15);
    drain();

    src_idle_pct = 70; snk_idle_pct = 19;
    // Fill the descriptor ring past its depth.
    for (int i = 0; i < QUEUE_DEPTH + 2; i++) add_packet(0, 1);
    pending_reqs.push_back(req(REQ_PEEK));
    pending_reqs.push_back(req(REQ_CLEAR));
    add_random(5);
    pending_reqs.push_back(req(REQ_CLEAR));
    drain();

    src_idle_pct = 0; snk_idle_pct = 0;
    hold_req = 1'b1;
    add_random(10);
    drain();

    repeat (20) @(posedge clk);
    $display("covered: %0d results checked, %0d packets popped", checked, packets_popped);
    $display("statuses ok/empty/big/full/nospace: %0d/%0d/%0d/%0d/%0d", status_seen[0],
             status_seen[1], status_seen[2], status_seen[3], status_seen[4]);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: packet_descriptor_fifo_unit.f
rtl/pdf_pkg.sv
rtl/pdf_if.sv
rtl/pdf_ram.sv
rtl/pdf_store.sv
rtl/packet_descriptor_fifo_unit.sv
tb/tb_packet_descriptor_fifo_unit.sv
